### sv/sinco_pkg.sv
package sinco_pkg;

    localparam int unsigned PHASE_BITS_DEF      = 32;
    localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
    localparam int unsigned SAMPLE_BITS_DEF     = 16;

    localparam int unsigned INC_BITS  = 32;
    localparam int unsigned AMP_BITS  = 16;
    localparam int unsigned CFG_BITS  = 32;
    localparam int unsigned TAB_W     = 15;
    localparam int unsigned PROD_FRAC = 30;

    localparam logic [INC_BITS-1:0] INC_RESET = 32'd42852281;
    localparam logic [AMP_BITS-1:0] AMP_RESET = 16'd16384;
    localparam logic [AMP_BITS-1:0] AMP_FULL  = 16'd32768;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam int unsigned FIFO_DEPTH    = 4;
    localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef enum logic
    {
        CFG_PHASE_INCREMENT = 1'b0,
        CFG_AMPLITUDE       = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic                     full;
        logic                     empty;
        logic [FIFO_CNT_BITS-1:0] count;
    } fifo_status_t;

    typedef struct packed
    {
        logic tbl_ready;
    } back_status_t;

    // sin(pi/2 * idx / 2^abits) in unsigned Q0.15, Q30 Taylor series through x^15
    function automatic logic [TAB_W-1:0] quarter_entry(input int unsigned idx,
                                                       input int unsigned abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q15;
        x    = (HALF_PI_Q30 * 64'(idx) + (64'd1 << (abits - 1))) >> abits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - term;
        q15  = (sum + 64'd16384) >> 15;
        if (q15 > 64'd32767)
        begin
            q15 = 64'd32767;
        end
        return q15[TAB_W-1:0];
    endfunction

endpackage

### sv/sinco_ram.sv
module sinco_ram
#(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/sinco_fifo.sv
module sinco_fifo
    import sinco_pkg::*;
#(
    parameter int unsigned WIDTH = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fifo_status_t     status
);

    logic [WIDTH-1:0]         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       wr_ptr_reg;
    logic [FIFO_AW-1:0]       rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic [FIFO_CNT_BITS-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + FIFO_CNT_BITS'(1);
            2'b01:   count_next = count_reg - FIFO_CNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

### sv/sinco_front.sv
module sinco_front
    import sinco_pkg::*;
#(
    parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
    parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    localparam int unsigned EW             = TABLE_ADDR_BITS + 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_stall,
    input  logic                phase_reset,
    input  logic [INC_BITS-1:0] phase_inc,
    input  fifo_status_t        fifo_status,
    input  back_status_t        back_status,
    output logic                push,
    output logic [EW-1:0]       push_data
);

    localparam int unsigned A = TABLE_ADDR_BITS;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [1:0]            quad;
    logic [A-1:0]          addr;
    logic [A:0]            taddr;

    assign tick_stall = fifo_status.full || !back_status.tbl_ready;
    assign push       = tick_valid && !tick_stall;

    assign phase_cur  = phase_reset ? '0 : phase_reg;
    assign phase_next = phase_cur + PHASE_BITS'(phase_inc);
    assign quad       = phase_cur[PHASE_BITS-1 -: 2];
    assign addr       = phase_cur[PHASE_BITS-3 -: A];
    assign taddr      = quad[0] ? ((A+1)'(1) << A) - {1'b0, addr} : {1'b0, addr};
    assign push_data  = {quad[1], taddr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

### sv/sinco_back.sv
module sinco_back
    import sinco_pkg::*;
#(
    parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF,
    localparam int unsigned EW             = TABLE_ADDR_BITS + 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [AMP_BITS-1:0]           amplitude,
    input  logic                          fifo_empty,
    input  logic [EW-1:0]                 pop_data,
    output logic                          pop,
    output back_status_t                  status,
    output logic                          sample_valid,
    input  logic                          sample_stall,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int unsigned A         = TABLE_ADDR_BITS;
    localparam int unsigned TAB_DEPTH = (2 ** A) + 1;
    localparam int unsigned TAW       = A + 1;
    localparam int unsigned P1        = AMP_BITS + TAB_W;
    localparam int unsigned P2        = P1 + SAMPLE_BITS - 1;
    localparam logic [TAW-1:0] LAST   = TAW'(2 ** A);
    localparam logic [SAMPLE_BITS-2:0] FULL = {(SAMPLE_BITS-1){1'b1}};

    logic [TAB_W-1:0] tab [TAB_DEPTH];

    for (genvar g = 0; g < TAB_DEPTH; g++)
    begin : g_tab
        localparam logic [TAB_W-1:0] V = quarter_entry(g, A);
        assign tab[g] = V;
    end

    logic             fill_rd_reg;
    logic [TAW-1:0]   fill_idx_reg;
    logic             fill_we_reg;
    logic [TAW-1:0]   fill_waddr_reg;
    logic [TAB_W-1:0] fill_wdata_reg;
    logic             tbl_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_rd_reg   <= 1'b1;
            fill_idx_reg  <= '0;
            fill_we_reg   <= 1'b0;
            tbl_ready_reg <= 1'b0;
        end
        else
        begin
            fill_we_reg <= fill_rd_reg;
            if (fill_rd_reg)
            begin
                if (fill_idx_reg == LAST)
                begin
                    fill_rd_reg <= 1'b0;
                end
                else
                begin
                    fill_idx_reg <= fill_idx_reg + TAW'(1);
                end
            end
            if (fill_we_reg && !fill_rd_reg)
            begin
                tbl_ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_waddr_reg <= fill_idx_reg;
        fill_wdata_reg <= tab[fill_idx_reg];
    end

    assign status.tbl_ready = tbl_ready_reg;

    logic                   adv;
    logic [TAB_W-1:0]       rd_data;
    logic                   s1_valid_reg;
    logic                   s1_neg_reg;
    logic                   s2_valid_reg;
    logic                   s2_neg_reg;
    logic [P1-1:0]          s2_prod_reg;
    logic                   s3_valid_reg;
    logic                   s3_neg_reg;
    logic [P2-1:0]          s3_prod_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [AMP_BITS-1:0]    amp_c;
    logic [SAMPLE_BITS-2:0] mag;
    logic [SAMPLE_BITS-1:0] mag_ext;

    assign adv = !out_valid_reg || !sample_stall;
    assign pop = adv && !fifo_empty;

    sinco_ram
    #(
        .WIDTH (TAB_W),
        .DEPTH (TAB_DEPTH)
    )
    u_tab
    (
        .clk     (clk),
        .wr_en   (fill_we_reg),
        .wr_addr (fill_waddr_reg),
        .wr_data (fill_wdata_reg),
        .rd_en   (adv),
        .rd_addr (pop_data[TAW-1:0]),
        .rd_data (rd_data)
    );

    assign amp_c   = (amplitude > AMP_FULL) ? AMP_FULL : amplitude;
    assign mag     = s3_prod_reg[PROD_FRAC +: (SAMPLE_BITS - 1)];
    assign mag_ext = {1'b0, mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_neg_reg  <= pop_data[EW-1];
            s2_neg_reg  <= s1_neg_reg;
            s2_prod_reg <= P1'(amp_c) * P1'(rd_data);
            s3_neg_reg  <= s2_neg_reg;
            s3_prod_reg <= P2'(s2_prod_reg) * P2'(FULL);
            sample_reg  <= s3_neg_reg ? (SAMPLE_BITS'(0) - mag_ext) : mag_ext;
        end
    end

    assign sample_valid = out_valid_reg;
    assign sample       = sample_reg;

endmodule

### sv/sine_oscillator_nco.sv
// Sine oscillator (DDS). Each tick transfer yields one signed sample,
// amplitude * sin(phase) at full scale 2^(SAMPLE_BITS-1)-1, truncated toward
// zero; the phase accumulator (cleared first when phase_reset is set) then
// advances by the tuning word. Sustained rate is one sample per clock while
// sample_stall is low. After its tick transfer a sample passes through the
// queue read with table lookup, two multiply stages and the output register.
// A stalled sample freezes the whole back end; ticks keep being taken until
// the four-entry queue between the phase front end and the lookup/multiply
// back end fills. After reset the quarter-wave table RAM is loaded, one
// entry per cycle; tick_stall stays high until it is done. Configuration
// writes take effect at once; make them only while no sample is in flight.
module sine_oscillator_nco
    import sinco_pkg::*;
#(
    parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
    parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data,
    input  logic                          tick_valid,
    output logic                          tick_stall,
    input  logic                          phase_reset,
    output logic                          sample_valid,
    input  logic                          sample_stall,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int unsigned EW = TABLE_ADDR_BITS + 2;

    logic [INC_BITS-1:0] inc_reg;
    logic [AMP_BITS-1:0] amp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg <= INC_RESET;
            amp_reg <= AMP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PHASE_INCREMENT: inc_reg <= cfg_data[INC_BITS-1:0];
                CFG_AMPLITUDE:       amp_reg <= cfg_data[AMP_BITS-1:0];
            endcase
        end
    end

    fifo_status_t  fstat;
    back_status_t  bstat;
    logic          push;
    logic          pop;
    logic [EW-1:0] push_data;
    logic [EW-1:0] pop_data;

    sinco_front
    #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_stall  (tick_stall),
        .phase_reset (phase_reset),
        .phase_inc   (inc_reg),
        .fifo_status (fstat),
        .back_status (bstat),
        .push        (push),
        .push_data   (push_data)
    );

    sinco_fifo
    #(
        .WIDTH (EW)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fstat)
    );

    sinco_back
    #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .amplitude    (amp_reg),
        .fifo_empty   (fstat.empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .status       (bstat),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample)
    );

`ifndef ASSERT_OFF
    a_no_tick_before_table: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |-> bstat.tbl_ready)
        else $error("tick transfer before table load finished");

    a_no_sample_before_table: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid |-> bstat.tbl_ready)
        else $error("sample valid before table load finished");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.count <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !fstat.full) |=> (fstat.count == $past(fstat.count) + 1'b1))
        else $error("queue count did not follow push");
`endif

endmodule
